// File: src/video_register_port_assert.svh
// ---------------------------------------------------------------------------
// video_register_port_assert.svh
// Assertion macros used by the register port controller (vrp_ctrl).
// ---------------------------------------------------------------------------
`ifndef VIDEO_REGISTER_PORT_ASSERT_SVH
`define VIDEO_REGISTER_PORT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define VRP_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("video register port check failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define VRP_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("video register port check failed");

`endif

// File: src/vrp_pkg.sv
// ---------------------------------------------------------------------------
// vrp_pkg
// Types, codes and address constants of the video register port.
// ---------------------------------------------------------------------------
`default_nettype none

package vrp_pkg;

	localparam int TableBytes = 1024;
	localparam int NtDepth    = 2 * TableBytes;
	localparam int NtAw       = $clog2(NtDepth);
	localparam int PtrW       = 14;
	localparam int PalDepth   = 32;
	localparam int PalAw      = $clog2(PalDepth);
	localparam int PalW       = 6;

	localparam logic [PtrW-1:0] PalBase = 14'h3F00;
	localparam logic [PtrW-1:0] PalEnd  = 14'h3F20;
	localparam logic [PtrW-1:0] NtBase  = 14'h2000;
	localparam logic [PtrW-1:0] NtEnd   = 14'h3000;
	localparam logic [PtrW-1:0] StepInc = 14'd1;
	localparam logic [PtrW-1:0] StepRow = 14'd32;

	localparam int IncBit = 2;

	typedef enum logic [2:0] {
		CMD_CTRL_WR   = 3'd0,
		CMD_MASK_WR   = 3'd1,
		CMD_SCROLL_WR = 3'd2,
		CMD_ADDR_WR   = 3'd3,
		CMD_DATA_WR   = 3'd4,
		CMD_DATA_RD   = 3'd5,
		CMD_STATUS_RD = 3'd6,
		CMD_STATUS_LD = 3'd7
	} command_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic accept;
		logic execute;
		logic clear_en;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: src/vrp_datapath.sv
// ---------------------------------------------------------------------------
// vrp_datapath
// Register file, address pointer, palette and name table memory.
// ---------------------------------------------------------------------------
`default_nettype none

module vrp_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire vrp_pkg::dp_cmd_t cmd,
	output vrp_pkg::dp_sts_t    sts,
	input  wire logic [2:0]     command_in,
	input  wire logic [7:0]     data_in,
	output logic      [7:0]     read_data,
	output logic      [7:0]     ctrl_value,
	output logic      [7:0]     mask_value,
	output logic      [7:0]     scroll_x,
	output logic      [7:0]     scroll_y
);
	import vrp_pkg::*;

	command_t              cmd_q;
	logic [7:0]            data_q;
	logic [7:0]            control_q;
	logic [7:0]            mask_q;
	logic [7:0]            scroll_h_q;
	logic [7:0]            scroll_v_q;
	logic                  scroll_tog_q;
	logic                  addr_tog_q;
	logic [PtrW-1:0]       ptr_q;
	logic [7:0]            status_q;
	logic [7:0]            read_data_q;
	logic [NtAw-1:0]       clr_cnt_q;
	logic [PalW-1:0]       pal_q [PalDepth];
	logic [7:0]            nt_mem [NtDepth];
	logic [7:0]            nt_rdata_q;

	logic                  pal_hit;
	logic                  nt_hit;
	logic [PalAw-1:0]      pal_idx;
	logic [NtAw-1:0]       nt_idx;
	logic [PtrW-1:0]       nt_off;
	logic [PtrW-1:0]       ptr_next;
	logic [7:0]            rd_val;
	logic                  nt_we;

	assign pal_hit  = (ptr_q >= PalBase) && (ptr_q < PalEnd);
	assign nt_hit   = (ptr_q >= NtBase) && (ptr_q < NtEnd);
	assign pal_idx  = ptr_q[PalAw-1:0];
	assign nt_off   = ptr_q - NtBase;
	assign nt_idx   = nt_off[NtAw-1:0];
	assign ptr_next = ptr_q + (control_q[IncBit] ? StepRow : StepInc);
	assign nt_we    = cmd.execute && (cmd_q == CMD_DATA_WR) && nt_hit;

	always_comb begin
		rd_val = 8'h00;
		unique case (cmd_q)
			CMD_DATA_RD: begin
				if (pal_hit) begin
					rd_val = {2'b00, pal_q[pal_idx]};
				end else if (nt_hit) begin
					rd_val = nt_rdata_q;
				end
			end
			CMD_STATUS_RD: rd_val = status_q;
			default:       rd_val = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q  <= CMD_CTRL_WR;
			data_q <= 8'h00;
		end else if (cmd.accept) begin
			cmd_q  <= command_t'(command_in);
			data_q <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q    <= 8'h00;
			mask_q       <= 8'h00;
			scroll_h_q   <= 8'h00;
			scroll_v_q   <= 8'h00;
			scroll_tog_q <= 1'b0;
			addr_tog_q   <= 1'b0;
			ptr_q        <= '0;
			status_q     <= 8'h00;
			read_data_q  <= 8'h00;
			for (int i = 0; i < PalDepth; i++) begin
				pal_q[i] <= '0;
			end
		end else if (cmd.execute) begin
			read_data_q <= rd_val;
			unique case (cmd_q)
				CMD_CTRL_WR: control_q <= data_q;
				CMD_MASK_WR: mask_q <= data_q;
				CMD_SCROLL_WR: begin
					if (!scroll_tog_q) begin
						scroll_h_q <= data_q;
					end else begin
						scroll_v_q <= data_q;
					end
					scroll_tog_q <= !scroll_tog_q;
				end
				CMD_ADDR_WR: begin
					if (!addr_tog_q) begin
						ptr_q <= {data_q[PtrW-9:0], 8'h00};
					end else begin
						ptr_q <= {ptr_q[PtrW-1:8], data_q};
					end
					addr_tog_q <= !addr_tog_q;
				end
				CMD_DATA_WR: begin
					if (pal_hit) begin
						pal_q[pal_idx] <= data_q[PalW-1:0];
					end
					ptr_q <= ptr_next;
				end
				CMD_DATA_RD: ptr_q <= ptr_next;
				CMD_STATUS_RD: begin
					status_q     <= {1'b0, status_q[6:0]};
					addr_tog_q   <= 1'b0;
					scroll_tog_q <= 1'b0;
				end
				CMD_STATUS_LD: status_q <= data_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_en) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign sts.clear_last = (clr_cnt_q == NtAw'(NtDepth - 1));

	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			nt_mem[clr_cnt_q] <= 8'h00;
		end else if (nt_we) begin
			nt_mem[nt_idx] <= data_q;
		end
	end

	always_ff @(posedge clk) begin
		nt_rdata_q <= nt_mem[nt_idx];
	end

	assign read_data  = read_data_q;
	assign ctrl_value = control_q;
	assign mask_value = mask_q;
	assign scroll_x   = scroll_h_q;
	assign scroll_y   = scroll_v_q;

endmodule

`default_nettype wire

// File: src/vrp_ctrl.sv
// ---------------------------------------------------------------------------
// vrp_ctrl
// Controller: memory clearing pass, item acceptance and result strobe.
// ---------------------------------------------------------------------------
`default_nettype none
`include "video_register_port_assert.svh"

module vrp_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output logic             done,
	output vrp_pkg::dp_cmd_t cmd,
	input  wire vrp_pkg::dp_sts_t sts
);
	import vrp_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clear_last) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_EXEC;
			ST_EXEC:  state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd.accept   = 1'b0;
		cmd.execute  = 1'b0;
		cmd.clear_en = 1'b0;
		busy         = 1'b1;
		unique case (state_q)
			ST_CLEAR: cmd.clear_en = 1'b1;
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_EXEC: cmd.execute = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.execute;
		end
	end

	assign done = done_q;

	`VRP_ASSERT_NEXT(a_exec_gives_done, state_q == ST_EXEC, done_q)
	`VRP_ASSERT_NEXT(a_done_single, done_q, !done_q)
	`VRP_ASSERT_NEXT(a_accept_to_exec, start && !busy, state_q == ST_EXEC)
	`VRP_ASSERT_NOW(a_clear_no_accept, state_q == ST_CLEAR, busy && !cmd.accept)

endmodule

`default_nettype wire

// File: src/video_register_port.sv
// ---------------------------------------------------------------------------
// video_register_port
// CPU-side register port of a picture processor with palette and name table.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake        Payload
//   -------  ---------------  ----------------------------------------------
//   input    start / busy     command, data
//   result   done (strobe)    read_data, ctrl_value, mask_value, scroll_x/y
//
// An item is taken at an edge with start high and busy low. The next cycle
// executes it against the registered name table read; done, registered from
// that execute cycle, is high for a single cycle. A new item may be taken
// in the cycle that done is high. After reset, busy stays high while the
// 2048-entry name table memory is cleared one entry per cycle. The receiver
// cannot stall; each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module video_register_port (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] command,
	input  wire logic [7:0] data,
	output logic            done,
	output logic      [7:0] read_data,
	output logic      [7:0] ctrl_value,
	output logic      [7:0] mask_value,
	output logic      [7:0] scroll_x,
	output logic      [7:0] scroll_y
);
	import vrp_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	vrp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (dp_cmd),
		.sts    (dp_sts)
	);

	vrp_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.sts        (dp_sts),
		.command_in (command),
		.data_in    (data),
		.read_data  (read_data),
		.ctrl_value (ctrl_value),
		.mask_value (mask_value),
		.scroll_x   (scroll_x),
		.scroll_y   (scroll_y)
	);

endmodule

`default_nettype wire
